>>> hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_response;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [9:0]  status_code;
    logic [1:0]  body_kind;
    logic [31:0] body_length;
    logic        keep_alive;
    logic [15:0] head_length;
  } out_item_t;

  typedef struct packed {
    logic        in_headers;
    logic [3:0]  parse_state;
    logic [4:0]  name_length;
    logic [5:0]  name_match;
    logic [15:0] value_length;
    logic [31:0] value_accum;
    logic        value_bad;
    logic [9:0]  code_accum;
    logic [2:0]  code_digits;
    logic [9:0]  status_reg;
    logic [1:0]  body_reg;
    logic [31:0] length_reg;
    logic        keep_reg;
    logic        failed;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    in_headers:   1'b0,
    parse_state:  4'd0,
    name_length:  5'd0,
    name_match:   6'h3f,
    value_length: 16'd0,
    value_accum:  32'd0,
    value_bad:    1'b0,
    code_accum:   10'd0,
    code_digits:  3'd0,
    status_reg:   10'd0,
    body_reg:     2'd0,
    length_reg:   32'd0,
    keep_reg:     1'b0,
    failed:       1'b0
  };

  localparam logic [2:0] EV_MORE   = 3'd0;
  localparam logic [2:0] EV_LINE   = 3'd1;
  localparam logic [2:0] EV_HEADER = 3'd2;
  localparam logic [2:0] EV_HEAD   = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  localparam logic [1:0] BODY_NONE    = 2'd0;
  localparam logic [1:0] BODY_LENGTH  = 2'd1;
  localparam logic [1:0] BODY_CHUNKED = 2'd2;

  localparam logic [15:0] HEAD_LIMIT_RST = 16'd4096;

  localparam int NUM_SPELL = 6;

  // spellings of the recognised header names, right aligned
  localparam logic [135:0] SPELL [NUM_SPELL] = '{
    136'("Connection"), 136'("connection"),
    136'("Content-Length"), 136'("content-length"),
    136'("Transfer-Encoding"), 136'("transfer-encoding")
  };
  localparam logic [4:0] SPELL_LEN [NUM_SPELL] = '{
    5'd10, 5'd10, 5'd14, 5'd14, 5'd17, 5'd17
  };

  localparam logic [5:0] MATCH_CONN  = 6'h03;
  localparam logic [5:0] MATCH_CLEN  = 6'h0c;
  localparam logic [5:0] MATCH_TENC  = 6'h30;

  function automatic logic [5:0] name_step(logic [5:0] m, logic [4:0] pos, logic [7:0] c);
    logic [5:0] res;
    logic [4:0] off;
    logic [7:0] bitpos;
    res = m;
    for (int k = 0; k < NUM_SPELL; k++) begin
      off    = SPELL_LEN[k] - 5'd1 - pos;
      bitpos = {off, 3'b000};
      if (pos >= SPELL_LEN[k]) begin
        res[k] = 1'b0;
      end else if (SPELL[k][bitpos +: 8] != c) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [5:0] name_close(logic [5:0] m, logic [4:0] len);
    logic [5:0] res;
    res = m;
    for (int k = 0; k < NUM_SPELL; k++) begin
      if (len != SPELL_LEN[k]) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/hrhp_step.sv
module hrhp_step
  import hrhp_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  parse_t                st_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  input  in_item_t              item_i,
  input  logic [15:0]           head_limit_i,
  output parse_t                st_nxt,
  output logic [COUNT_BITS-1:0] cnt_nxt,
  output out_item_t             res_nxt
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [3:0] SL_H0     = 4'd0;
  localparam logic [3:0] SL_T1     = 4'd1;
  localparam logic [3:0] SL_T2     = 4'd2;
  localparam logic [3:0] SL_P      = 4'd3;
  localparam logic [3:0] SL_SLASH  = 4'd4;
  localparam logic [3:0] SL_VER0   = 4'd5;
  localparam logic [3:0] SL_VER    = 4'd6;
  localparam logic [3:0] SL_CODE0  = 4'd7;
  localparam logic [3:0] SL_CODE   = 4'd8;
  localparam logic [3:0] SL_REASON0 = 4'd9;
  localparam logic [3:0] SL_REASON = 4'd10;
  localparam logic [3:0] SL_LF     = 4'd11;

  localparam logic [3:0] HL_START  = 4'd0;
  localparam logic [3:0] HL_NAME   = 4'd1;
  localparam logic [3:0] HL_VSKIP  = 4'd2;
  localparam logic [3:0] HL_VALUE  = 4'd3;
  localparam logic [3:0] HL_LF     = 4'd4;
  localparam logic [3:0] HL_ENDLF  = 4'd5;
  localparam logic [3:0] HL_DONE   = 4'd6;

  parse_t                base;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [7:0]            c;
  logic                  is_digit;
  logic                  printable;
  logic [3:0]            dval;
  logic                  limit_hit;
  logic                  err;
  logic [2:0]            ev;
  logic                  vstart;
  logic [15:0]           v_len;
  logic [31:0]           v_acc;
  logic                  v_bad;
  logic [15:0]           vlen_n;
  logic [35:0]           prod;
  logic                  ovf;
  logic                  vbad_n;
  logic [31:0]           vacc_n;
  logic [13:0]           code_wide;
  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         out_cnt;

  assign base     = item_i.new_response ? PARSE_CLEAR : st_i;
  assign base_cnt = item_i.new_response ? '0 : cnt_i;
  assign c        = item_i.data_byte;
  assign is_digit = (c >= "0") && (c <= "9");
  assign printable = (c >= 8'd32) && (c <= 8'd126);
  assign dval     = 4'(c - "0");
  assign cnt_ext  = CW'(base_cnt);
  assign limit_hit = (cnt_ext >= CW'(head_limit_i)) || (base_cnt == '1);

  // value byte update, started afresh when leaving the space skip
  assign vstart = (base.parse_state == HL_VSKIP);
  assign v_len  = vstart ? 16'd0 : base.value_length;
  assign v_acc  = vstart ? 32'd0 : base.value_accum;
  assign v_bad  = vstart ? 1'b0 : base.value_bad;
  assign vlen_n = (v_len == 16'hffff) ? v_len : v_len + 16'd1;
  assign prod   = {1'b0, v_acc, 3'b000} + {3'b000, v_acc, 1'b0} + {32'd0, dval};
  assign ovf    = (prod[35:32] != 4'd0);
  assign vbad_n = v_bad | ~is_digit | ovf;
  assign vacc_n = (is_digit && !v_bad && !ovf) ? prod[31:0] : v_acc;

  assign code_wide = {base.code_accum, 3'b000} + {2'b00, base.code_accum, 1'b0} + {10'd0, dval};

  always_comb begin
    st_nxt  = base;
    cnt_nxt = base_cnt;
    ev      = EV_MORE;
    err     = 1'b0;
    if (base.failed) begin
      ev = EV_ERROR;
    end else if (base.in_headers && base.parse_state == HL_DONE) begin
      ev = EV_MORE;
    end else if (limit_hit) begin
      ev = EV_ERROR;
      st_nxt.failed = 1'b1;
    end else begin
      cnt_nxt = base_cnt + 1'b1;
      if (!base.in_headers) begin
        st_nxt.parse_state = base.parse_state + 4'd1;
        case (base.parse_state)
          SL_H0: begin
            err = (c != "H") && (c != "h");
          end
          SL_T1, SL_T2: begin
            err = (c != "T") && (c != "t");
          end
          SL_P: begin
            err = (c != "P") && (c != "p");
          end
          SL_SLASH: begin
            err = (c != "/");
          end
          SL_VER0: begin
            err = !is_digit && (c != ".");
          end
          SL_VER: begin
            if (c != " ") begin
              err = !is_digit && (c != ".");
              st_nxt.parse_state = base.parse_state;
            end
          end
          SL_CODE0, SL_CODE: begin
            if (base.parse_state == SL_CODE && c == " ") begin
              err = (base.code_digits != 3'd3);
            end else begin
              err = !is_digit || (base.code_digits >= 3'd3);
              st_nxt.code_accum  = code_wide[9:0];
              st_nxt.code_digits = base.code_digits + 3'd1;
              if (base.parse_state == SL_CODE) begin
                st_nxt.parse_state = base.parse_state;
              end
            end
          end
          SL_REASON0: begin
          end
          SL_REASON: begin
            if (c != 8'h0d) begin
              st_nxt.parse_state = base.parse_state;
            end
          end
          SL_LF: begin
            err = (c != 8'h0a);
            st_nxt.status_reg  = base.code_accum;
            st_nxt.in_headers  = 1'b1;
            st_nxt.parse_state = HL_START;
            ev = EV_LINE;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end else begin
        case (base.parse_state)
          HL_START: begin
            if (c == 8'h0d) begin
              st_nxt.parse_state = HL_ENDLF;
            end else begin
              err = !printable;
              st_nxt.name_match  = name_step(6'h3f, 5'd0, c);
              st_nxt.name_length = 5'd1;
              st_nxt.parse_state = HL_NAME;
            end
          end
          HL_NAME: begin
            err = !printable;
            if (c != ":") begin
              st_nxt.name_match  = name_step(base.name_match, base.name_length, c);
              st_nxt.name_length = (base.name_length == 5'd31) ?
                                   base.name_length : base.name_length + 5'd1;
            end else begin
              st_nxt.name_match  = name_close(base.name_match, base.name_length);
              st_nxt.parse_state = HL_VSKIP;
            end
          end
          HL_VSKIP, HL_VALUE: begin
            if (base.parse_state == HL_VALUE && c == 8'h0d) begin
              st_nxt.parse_state = HL_LF;
            end else if (base.parse_state == HL_VSKIP && c == " ") begin
              st_nxt.parse_state = HL_VSKIP;
            end else begin
              st_nxt.value_length = vlen_n;
              st_nxt.value_accum  = vacc_n;
              st_nxt.value_bad    = vbad_n;
              st_nxt.parse_state  = HL_VALUE;
            end
          end
          HL_LF: begin
            err = (c != 8'h0a);
            if ((base.name_match & MATCH_CLEN) != 6'd0) begin
              if (base.value_bad) begin
                err = 1'b1;
              end
              st_nxt.body_reg   = BODY_LENGTH;
              st_nxt.length_reg = base.value_accum;
            end
            if ((base.name_match & MATCH_CONN) != 6'd0) begin
              st_nxt.keep_reg = (base.value_length > 16'd5);
            end
            if ((base.name_match & MATCH_TENC) != 6'd0) begin
              st_nxt.body_reg = BODY_CHUNKED;
            end
            st_nxt.parse_state = HL_START;
            ev = EV_HEADER;
          end
          HL_ENDLF: begin
            err = (c != 8'h0a);
            st_nxt.parse_state = HL_DONE;
            ev = EV_HEAD;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end
      if (err) begin
        st_nxt        = base;
        st_nxt.failed = 1'b1;
        ev            = EV_ERROR;
      end
    end
  end

  assign out_cnt = CW'(cnt_nxt);

  always_comb begin
    res_nxt.event_res   = ev;
    res_nxt.status_code = st_nxt.status_reg;
    res_nxt.body_kind   = st_nxt.body_reg;
    res_nxt.body_length = st_nxt.length_reg;
    res_nxt.keep_alive  = st_nxt.keep_reg;
    res_nxt.head_length = out_cnt[15:0];
  end

endmodule

>>> hw/rtl/http_response_head_parser_unit.sv
// HTTP/1.1 response head parser. One byte of the response head enters per transaction
// and gives exactly one result transaction with the event for that byte (more needed,
// status line done, header line done, head complete, error) together with the status
// code, body kind, content length, keep-alive flag and head byte count gathered so
// far. Setting new_response clears all parse state before its byte is taken; errors
// are sticky until then. The parse step is combinational between the input register
// and the result register, so a byte's result is loaded into the result register after
// the byte is accepted, provided the result register is empty or being read out at
// that time; a result that is not taken holds the byte behind it. A new byte is
// accepted every cycle while results are taken. cfg_wr_en loads the head byte limit
// (reset 4096); write it only while no transaction is in flight.
module http_response_head_parser_unit
  import hrhp_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                  in_vld_r;
  in_item_t              in_item_r;
  parse_t                st_r;
  parse_t                st_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  out_vld_r;
  out_item_t             out_item_r;
  out_item_t             res_nxt;
  logic [15:0]           head_limit_r;
  logic                  advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  hrhp_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .st_i         (st_r),
    .cnt_i        (cnt_r),
    .item_i       (in_item_r),
    .head_limit_i (head_limit_r),
    .st_nxt       (st_nxt),
    .cnt_nxt      (cnt_nxt),
    .res_nxt      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      st_r         <= PARSE_CLEAR;
      cnt_r        <= '0;
      head_limit_r <= HEAD_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        head_limit_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        st_r      <= st_nxt;
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

>>> tb/head_parse_checker.sv
module head_parse_checker
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  localparam logic [3:0] SP_H           = 4'd0;
  localparam logic [3:0] SP_T1          = 4'd1;
  localparam logic [3:0] SP_T2          = 4'd2;
  localparam logic [3:0] SP_P           = 4'd3;
  localparam logic [3:0] SP_SLASH       = 4'd4;
  localparam logic [3:0] SP_VER_FIRST   = 4'd5;
  localparam logic [3:0] SP_VER         = 4'd6;
  localparam logic [3:0] SP_CODE_FIRST  = 4'd7;
  localparam logic [3:0] SP_CODE        = 4'd8;
  localparam logic [3:0] SP_REASON_FIRST = 4'd9;
  localparam logic [3:0] SP_REASON      = 4'd10;
  localparam logic [3:0] SP_LF          = 4'd11;

  localparam logic [3:0] HP_NAME_START  = 4'd0;
  localparam logic [3:0] HP_NAME        = 4'd1;
  localparam logic [3:0] HP_VAL_START   = 4'd2;
  localparam logic [3:0] HP_VAL         = 4'd3;
  localparam logic [3:0] HP_LF          = 4'd4;
  localparam logic [3:0] HP_END_LF      = 4'd5;
  localparam logic [3:0] HP_DONE        = 4'd6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam int unsigned COUNT_TOP = 65535;

  string spellings [6] = '{"Connection", "connection", "Content-Length", "content-length",
                           "Transfer-Encoding", "transfer-encoding"};

  logic        hdr_mode;
  logic [3:0]  ph;
  logic [4:0]  nm_len;
  logic [5:0]  nm_hits;
  logic [15:0] val_len;
  logic [31:0] val_num;
  logic        val_bad;
  logic [9:0]  code_num;
  logic [2:0]  code_cnt;
  logic [9:0]  status_q;
  logic [1:0]  body_q;
  logic [31:0] clen_q;
  logic        keep_q;
  int unsigned bytes_q;
  logic        broken;
  logic [15:0] head_limit_q;

  out_item_t predicted_results [$];
  out_item_t want;
  int        mismatches = 0;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic logic up_or_low(logic [7:0] c, logic [7:0] up);
    return c == up || c == (up | 8'h20);
  endfunction

  function automatic void clear_parser();
    hdr_mode = 1'b0;
    ph       = SP_H;
    nm_len   = '0;
    nm_hits  = '1;
    val_len  = '0;
    val_num  = '0;
    val_bad  = 1'b0;
    code_num = '0;
    code_cnt = '0;
    status_q = '0;
    body_q   = BODY_NONE;
    clen_q   = '0;
    keep_q   = 1'b0;
    bytes_q  = 0;
    broken   = 1'b0;
  endfunction

  function automatic void name_hit(logic [7:0] c);
    for (int k = 0; k < 6; k++) begin
      if (nm_len >= spellings[k].len() || spellings[k][nm_len] != c) begin
        nm_hits[k] = 1'b0;
      end
    end
    if (nm_len < 5'd31) begin
      nm_len = nm_len + 5'd1;
    end
  endfunction

  function automatic void value_take(logic [7:0] c);
    logic [35:0] v;
    if (val_len != 16'hffff) begin
      val_len = val_len + 16'd1;
    end
    if (!is_digit(c)) begin
      val_bad = 1'b1;
    end else if (!val_bad) begin
      v = {4'd0, val_num} * 36'd10 + 36'(c - CH_ZERO);
      if (v > 36'hffffffff) begin
        val_bad = 1'b1;
      end else begin
        val_num = v[31:0];
      end
    end
  endfunction

  function automatic out_item_t advance_parser(in_item_t it);
    logic [7:0] c;
    logic [2:0] ev;
    logic       ok;
    logic       adv;
    out_item_t  r;
    c = it.data_byte;
    if (it.new_response) begin
      clear_parser();
    end
    ev  = EV_MORE;
    ok  = 1'b1;
    adv = 1'b0;
    if (broken) begin
      ev = EV_ERROR;
    end else if (hdr_mode && ph == HP_DONE) begin
      ev = EV_MORE;
    end else if (bytes_q >= head_limit_q || bytes_q >= COUNT_TOP) begin
      ev     = EV_ERROR;
      broken = 1'b1;
    end else begin
      bytes_q = bytes_q + 1;
      if (!hdr_mode) begin
        adv = 1'b1;
        case (ph)
          SP_H: begin
            ok = up_or_low(c, 8'h48);
          end
          SP_T1, SP_T2: begin
            ok = up_or_low(c, 8'h54);
          end
          SP_P: begin
            ok = up_or_low(c, 8'h50);
          end
          SP_SLASH: begin
            ok = (c == CH_SLASH);
          end
          SP_VER_FIRST: begin
            ok = is_digit(c) || c == CH_DOT;
          end
          SP_VER: begin
            ok  = is_digit(c) || c == CH_DOT || c == CH_SP;
            adv = (c == CH_SP);
          end
          SP_CODE_FIRST, SP_CODE: begin
            if (ph == SP_CODE && c == CH_SP) begin
              ok = (code_cnt == 3'd3);
            end else begin
              ok = is_digit(c) && code_cnt < 3'd3;
              if (ok) begin
                code_num = code_num * 10'd10 + 10'(c - CH_ZERO);
                code_cnt = code_cnt + 3'd1;
              end
              adv = (ph == SP_CODE_FIRST);
            end
          end
          SP_REASON_FIRST: begin
            ok = 1'b1;
          end
          SP_REASON: begin
            adv = (c == CH_CR);
          end
          SP_LF: begin
            adv = 1'b0;
            ok  = (c == CH_LF);
            if (ok) begin
              status_q = code_num;
              hdr_mode = 1'b1;
              ph       = HP_NAME_START;
              ev       = EV_LINE;
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        if (ok && adv) begin
          ph = ph + 4'd1;
        end
      end else begin
        case (ph)
          HP_NAME_START: begin
            if (c == CH_CR) begin
              ph = HP_END_LF;
            end else if (c < 8'd32 || c > 8'd126) begin
              ok = 1'b0;
            end else begin
              nm_len  = '0;
              nm_hits = '1;
              name_hit(c);
              ph = HP_NAME;
            end
          end
          HP_NAME: begin
            if (c < 8'd32 || c > 8'd126) begin
              ok = 1'b0;
            end else if (c != CH_COLON) begin
              name_hit(c);
            end else begin
              for (int k = 0; k < 6; k++) begin
                if (nm_len != spellings[k].len()) begin
                  nm_hits[k] = 1'b0;
                end
              end
              ph = HP_VAL_START;
            end
          end
          HP_VAL_START: begin
            if (c != CH_SP) begin
              val_len = '0;
              val_num = '0;
              val_bad = 1'b0;
              value_take(c);
              ph = HP_VAL;
            end
          end
          HP_VAL: begin
            if (c == CH_CR) begin
              ph = HP_LF;
            end else begin
              value_take(c);
            end
          end
          HP_LF: begin
            if (c != CH_LF || ((nm_hits & MATCH_CLEN) != 0 && val_bad)) begin
              ok = 1'b0;
            end else begin
              if ((nm_hits & MATCH_CLEN) != 0) begin
                body_q = BODY_LENGTH;
                clen_q = val_num;
              end
              if ((nm_hits & MATCH_CONN) != 0) begin
                keep_q = (val_len > 16'd5);
              end
              if ((nm_hits & MATCH_TENC) != 0) begin
                body_q = BODY_CHUNKED;
              end
              ph = HP_NAME_START;
              ev = EV_HEADER;
            end
          end
          HP_END_LF: begin
            ok = (c == CH_LF);
            if (ok) begin
              ph = HP_DONE;
              ev = EV_HEAD;
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      if (!ok) begin
        ev     = EV_ERROR;
        broken = 1'b1;
      end
    end
    r.event_res   = ev;
    r.status_code = status_q;
    r.body_kind   = body_q;
    r.body_length = clen_q;
    r.keep_alive  = keep_q;
    r.head_length = bytes_q[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      head_limit_q = HEAD_LIMIT_RST;
      predicted_results.delete();
    end else begin
      if (cfg_wr_en) begin
        head_limit_q = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(advance_parser(in_item));
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: ev %0d code %0d body %0d len %0d keep %0d head %0d",
                     out_item.event_res, out_item.status_code, out_item.body_kind,
                     out_item.body_length, out_item.keep_alive, out_item.head_length);
          end
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_item.event_res !== want.event_res ||
              out_item.status_code !== want.status_code ||
              out_item.body_kind !== want.body_kind ||
              out_item.body_length !== want.body_length ||
              out_item.keep_alive !== want.keep_alive ||
              out_item.head_length !== want.head_length) begin
            if (mismatches < 10) begin
              $display("mismatch: expected ev %0d code %0d body %0d len %0d keep %0d head %0d",
                       want.event_res, want.status_code, want.body_kind,
                       want.body_length, want.keep_alive, want.head_length);
              $display("          actual   ev %0d code %0d body %0d len %0d keep %0d head %0d",
                       out_item.event_res, out_item.status_code, out_item.body_kind,
                       out_item.body_length, out_item.keep_alive, out_item.head_length);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= predicted_results.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top
  import hrhp_pkg::*;
();

  localparam int         ITEMS       = 700;
  localparam int         PHASE_ITEMS = 140;
  localparam int         STALL_LIMIT = 2000;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_LF       = 8'h0a;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b1;
  out_item_t   out_item;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int       fail_count;
  int       pending;
  int       counted     = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  bit       calm        = 1'b0;
  in_item_t byte_stream [$];

  http_response_head_parser_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  head_parse_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic put(input logic [7:0] b, input logic nr = 1'b0);
    byte_stream.push_back(in_item_t'({b, nr}));
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i]);
    end
  endtask

  task automatic put_crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  function automatic string rand_text(input int n);
    string      s;
    logic [7:0] b;
    s = "";
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(32, 126));
      if (b == 8'h3a) begin
        b = 8'h78;
      end
      s = {s, $sformatf("%c", b)};
    end
    return s;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(0, 99) == 0) begin
      drain();
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic play_stream();
    while (byte_stream.size() != 0) begin
      calm = (counted >= ITEMS - 100);
      send_item(byte_stream.pop_front());
    end
  endtask

  task automatic add_status_line(input logic nr);
    string      upper;
    string      ver_chars;
    int         ndig;
    int         code_mode;
    logic [7:0] b;
    upper     = "HTTP";
    ver_chars = "0123456789.";
    for (int i = 0; i < 4; i++) begin
      put(8'(upper[i] | (8'h20 * $urandom_range(0, 1))), (i == 0) ? nr : 1'b0);
    end
    put("/");
    repeat ($urandom_range(1, 4)) put(ver_chars[$urandom_range(0, 10)]);
    put(" ");
    case ($urandom_range(0, 19))
      0: ndig = 2;
      1: ndig = 4;
      default: ndig = 3;
    endcase
    code_mode = $urandom_range(0, 5);
    repeat (ndig) begin
      case (code_mode)
        0: put("0");
        1: put("9");
        default: put(8'(8'h30 + $urandom_range(0, 9)));
      endcase
    end
    put(" ");
    // the first reason byte may be anything at all
    if ($urandom_range(0, 3) == 0) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      put(8'($urandom_range(65, 90)));
    end
    repeat ($urandom_range(0, 6)) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(32, 126));
      if (b == CH_CR) begin
        b = 8'h2a;
      end
      put(b);
    end
    put_crlf();
  endtask

  task automatic add_header();
    string nm;
    string val;
    case ($urandom_range(0, 5))
      0: begin
        nm = $urandom_range(0, 1) ? "Content-Length" : "content-length";
        case ($urandom_range(0, 7))
          0: val = "4294967295";
          1: val = "4294967296";
          2: val = "99999999999";
          3: val = "12a";
          4: val = "0";
          5: val = $sformatf("%0d", $urandom());
          default: val = $sformatf("%0d", $urandom_range(0, 99999));
        endcase
      end
      1: begin
        nm = $urandom_range(0, 1) ? "Connection" : "connection";
        case ($urandom_range(0, 2))
          0: val = "close";
          1: val = "keep-alive";
          default: val = rand_text($urandom_range(1, 8));
        endcase
      end
      2: begin
        nm  = $urandom_range(0, 1) ? "Transfer-Encoding" : "transfer-encoding";
        val = "chunked";
      end
      3: begin
        nm  = rand_text($urandom_range(1, 40));
        val = rand_text($urandom_range(0, 10));
      end
      4: begin
        nm  = {":", rand_text($urandom_range(0, 6))};
        val = rand_text($urandom_range(1, 6));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: nm = "Content-Lengt";
          1: nm = "Connectionx";
          default: nm = "TRANSFER-ENCODING";
        endcase
        val = rand_text($urandom_range(1, 8));
      end
    endcase
    put_text(nm);
    put(":");
    repeat ($urandom_range(0, 2)) put(" ");
    put_text(val);
    put_crlf();
  endtask

  task automatic build_response();
    int       r;
    int       idx;
    in_item_t tmp;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(5, 30)) begin
        put(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end else begin
      add_status_line(r != 3);
      repeat ($urandom_range(0, 3)) add_header();
      put_crlf();
      if (r == 1) begin
        idx = $urandom_range(0, byte_stream.size() - 1);
        tmp = byte_stream[idx];
        tmp.data_byte = 8'($urandom_range(0, 255));
        byte_stream[idx] = tmp;
      end else if (r == 2) begin
        repeat ($urandom_range(1, 10)) tmp = byte_stream.pop_back();
      end
    end
    counted += byte_stream.size();
    // bytes past the end of the head are ignored
    repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
    play_stream();
  endtask

  task automatic write_limit(input logic [15:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] limit);
    int goal;
    write_limit(limit);
    goal = counted + PHASE_ITEMS;
    while (counted < goal) begin
      build_response();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // short head with an empty-looking reason, then junk, error and sticky error
    put("h", 1'b1);
    put_text("TTP/9. 999 ");
    put(CH_CR);
    put_crlf();
    put_crlf();
    put(8'hff);
    put(8'h00, 1'b1);
    put(8'h80);
    counted += byte_stream.size();
    play_stream();
    drain();

    run_phase(16'd1);
    run_phase(16'd65535);
    run_phase(16'($urandom_range(16, 60)));
    run_phase(HEAD_LIMIT_RST);
    run_phase(16'd300);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
